// ===== rtl/core/tcce_pkg.sv =====
// Shared types, constants and the weight-to-level table for the threshold
// color-cycle echo block. No dependencies.
package tcce_pkg;

    localparam int FRAME_WIDTH    = 640;
    localparam int FRAME_HEIGHT   = 480;
    localparam int HISTORY_FRAMES = 6;

    localparam int PIXELS    = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W    = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int SLOT_W    = $clog2(HISTORY_FRAMES);
    localparam int STORED_W  = $clog2(HISTORY_FRAMES + 1);

    localparam int THRESH_W  = 8;
    localparam int WARMUP_W  = 16;
    localparam int COUNT_W   = 16;
    localparam int COLOR_W   = 8;

    localparam int GRAY_R    = 4899;
    localparam int GRAY_G    = 9617;
    localparam int GRAY_B    = 1868;
    localparam int GRAY_RND  = 8192;
    localparam int GRAY_SHR  = 14;
    localparam int GRAY_SUM_W = 23;

    localparam int STEPS     = 20;
    localparam int K_W       = 5;

    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd127;
    localparam logic [WARMUP_W-1:0] WARMUP_RESET = 16'd30;

    localparam logic [COLOR_W-1:0] LEVEL_TABLE [0:STEPS] = '{
        8'd0,   8'd13,  8'd26,  8'd38,  8'd51,  8'd64,  8'd77,
        8'd89,  8'd102, 8'd115, 8'd128, 8'd140, 8'd153, 8'd166,
        8'd179, 8'd191, 8'd204, 8'd217, 8'd230, 8'd242, 8'd255
    };

    typedef enum logic [1:0] {
        SEG_BG,
        SEG_GR,
        SEG_RB
    } tcce_seg_t;

    typedef enum logic {
        REG_THRESHOLD,
        REG_WARMUP
    } tcce_reg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              set;
        tcce_seg_t         seg;
        logic [K_W-1:0]    k;
        logic              push;
        logic [SLOT_W-1:0] slot;
        logic              echo_en;
        logic [SLOT_W-1:0] echo_idx;
        logic              fend;
    } tcce_item_t;

    function automatic logic [COLOR_W-1:0] tcce_level(input logic [K_W-1:0] k);
        logic [COLOR_W-1:0] lvl;
        lvl = '0;
        if (k <= K_W'(STEPS))
        begin
            lvl = LEVEL_TABLE[k];
        end
        return lvl;
    endfunction

endpackage

// ===== rtl/core/tcce_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/tcce_front.sv =====
// Front end: accepts pixel beats, computes gray and threshold, tracks frame
// phase and history slots, and hands a classified item to the queue. Uses tcce_pkg.
module tcce_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [tcce_pkg::THRESH_W-1:0]  threshold_level,
    input  logic [tcce_pkg::WARMUP_W-1:0]  warmup_frames,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [tcce_pkg::COLOR_W-1:0]   pix_blue,
    input  logic [tcce_pkg::COLOR_W-1:0]   pix_green,
    input  logic [tcce_pkg::COLOR_W-1:0]   pix_red,
    input  logic                           frame_end,
    input  logic                           q_full,
    output logic                           q_push,
    output tcce_pkg::tcce_item_t           q_item
);
    import tcce_pkg::*;

    logic [COUNT_W-1:0]    count_reg, count_next;
    tcce_seg_t             seg_reg, seg_next;
    logic [K_W-1:0]        k_reg, k_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [STORED_W-1:0]   stored_reg, stored_next;
    logic [SLOT_W-1:0]     oldest_reg, oldest_next;

    logic                  accept;
    logic [GRAY_SUM_W-1:0] gray_sum;
    logic [COLOR_W-1:0]    gray;
    logic                  push;
    logic                  full;
    logic [STORED_W:0]     slot_sum;
    logic [SLOT_W-1:0]     slot;
    logic [SLOT_W-1:0]     new_oldest;
    logic [STORED_W-1:0]   new_stored;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    assign gray_sum = GRAY_SUM_W'(GRAY_R) * GRAY_SUM_W'(pix_red)
                    + GRAY_SUM_W'(GRAY_G) * GRAY_SUM_W'(pix_green)
                    + GRAY_SUM_W'(GRAY_B) * GRAY_SUM_W'(pix_blue)
                    + GRAY_SUM_W'(GRAY_RND);
    assign gray = gray_sum[GRAY_SHR +: COLOR_W];

    assign push     = count_reg > warmup_frames;
    assign full     = stored_reg >= STORED_W'(HISTORY_FRAMES);
    assign slot_sum = (STORED_W+1)'(oldest_reg) + (STORED_W+1)'(stored_reg);

    always_comb
    begin
        slot       = oldest_reg;
        new_oldest = oldest_reg;
        new_stored = stored_reg;
        if (push)
        begin
            if (full)
            begin
                new_oldest = (oldest_reg == SLOT_W'(HISTORY_FRAMES - 1)) ?
                             '0 : oldest_reg + SLOT_W'(1);
            end
            else
            begin
                slot = (slot_sum >= (STORED_W+1)'(HISTORY_FRAMES)) ?
                       SLOT_W'(slot_sum - (STORED_W+1)'(HISTORY_FRAMES)) :
                       SLOT_W'(slot_sum);
                new_stored = stored_reg + STORED_W'(1);
            end
        end
    end

    assign q_push         = accept;
    assign q_item.addr     = addr_reg;
    assign q_item.set      = gray > threshold_level;
    assign q_item.seg      = seg_reg;
    assign q_item.k        = k_reg;
    assign q_item.push     = push;
    assign q_item.slot     = slot;
    assign q_item.echo_en  = new_stored != '0;
    assign q_item.echo_idx = new_oldest;
    assign q_item.fend     = frame_end;

    always_comb
    begin
        count_next  = count_reg;
        seg_next    = seg_reg;
        k_next      = k_reg;
        addr_next   = addr_reg;
        stored_next = stored_reg;
        oldest_next = oldest_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                addr_next   = '0;
                count_next  = count_reg + COUNT_W'(1);
                stored_next = new_stored;
                oldest_next = new_oldest;
                if (count_next == '0)
                begin
                    seg_next = SEG_BG;
                    k_next   = '0;
                end
                else if (k_reg == K_W'(STEPS - 1))
                begin
                    k_next = '0;
                    unique case (seg_reg)
                        SEG_BG:  seg_next = SEG_GR;
                        SEG_GR:  seg_next = SEG_RB;
                        default: seg_next = SEG_BG;
                    endcase
                end
                else
                begin
                    k_next = k_reg + K_W'(1);
                end
            end
            else
            begin
                addr_next = (addr_reg == ADDR_W'(PIXELS - 1)) ?
                            '0 : addr_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= COUNT_W'(1);
            seg_reg    <= SEG_BG;
            k_reg      <= K_W'(1);
            addr_reg   <= '0;
            stored_reg <= '0;
            oldest_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            seg_reg    <= seg_next;
            k_reg      <= k_next;
            addr_reg   <= addr_next;
            stored_reg <= stored_next;
            oldest_reg <= oldest_next;
        end
    end

`ifndef SYNTHESIS
    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        addr_reg <= ADDR_W'(PIXELS - 1))
        else $error("pixel address out of frame");
    a_history_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= STORED_W'(HISTORY_FRAMES) &&
        oldest_reg <= SLOT_W'(HISTORY_FRAMES - 1))
        else $error("history bookkeeping out of range");
    a_phase_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> k_reg == '0 && seg_reg == SEG_BG)
        else $error("phase not zero at counter wrap");
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && frame_end |=> addr_reg == '0)
        else $error("address not reset after frame end");
`endif

endmodule

// ===== rtl/core/tcce_queue.sv =====
// Short queue of classified items between front and back end.
// Uses tcce_pkg.
module tcce_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tcce_pkg::tcce_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output tcce_pkg::tcce_item_t head,
    output logic                 empty
);
    import tcce_pkg::*;

    tcce_item_t           entry_reg [0:Q_DEPTH-1];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full    = count_reg == Q_CNT_W'(Q_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/tcce_back.sv =====
// Back end: history read-modify-write, live and echo coloring, output register.
// Uses tcce_pkg and tcce_ram.
module tcce_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  tcce_pkg::tcce_item_t         q_head,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [tcce_pkg::COLOR_W-1:0] out_blue,
    output logic [tcce_pkg::COLOR_W-1:0] out_green,
    output logic [tcce_pkg::COLOR_W-1:0] out_red,
    output logic                         out_frame_end
);
    import tcce_pkg::*;

    logic                      adv;
    tcce_item_t                s2_reg;
    logic                      s2_valid_reg, s2_valid_next;
    logic                      fwd_reg;
    logic [HISTORY_FRAMES-1:0] fwd_data_reg;
    logic [HISTORY_FRAMES-1:0] rdata;
    logic [HISTORY_FRAMES-1:0] word;
    logic [HISTORY_FRAMES-1:0] new_word;
    logic                      we;
    logic                      echo;
    logic [COLOR_W-1:0]        hi, lo;
    logic [COLOR_W-1:0]        lb, lg, lr, eb, eg, er;
    logic [COLOR_W:0]          sb, sg, sr;

    logic                      out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]        out_blue_reg, out_green_reg, out_red_reg;
    logic                      out_fend_reg;

    assign adv           = !out_valid_reg || !out_stall;
    assign q_pop         = adv && !q_empty;
    assign s2_valid_next = adv ? q_pop : s2_valid_reg;
    assign out_valid_next = adv ? s2_valid_reg : out_valid_reg;

    tcce_ram #(
        .WIDTH (HISTORY_FRAMES),
        .DEPTH (PIXELS)
    ) u_history (
        .clk   (clk),
        .we    (we),
        .waddr (s2_reg.addr),
        .wdata (new_word),
        .re    (q_pop),
        .raddr (q_head.addr),
        .rdata (rdata)
    );

    // back-to-back access to one pixel: the write lands on the read edge
    assign word = fwd_reg ? fwd_data_reg : rdata;

    always_comb
    begin
        new_word = word;
        if (s2_reg.push)
        begin
            new_word[s2_reg.slot] = !s2_reg.set;
        end
    end

    assign we   = adv && s2_valid_reg && s2_reg.push;
    assign echo = s2_reg.echo_en && new_word[s2_reg.echo_idx];
    assign hi   = tcce_level(K_W'(STEPS) - s2_reg.k);
    assign lo   = tcce_level(s2_reg.k);

    always_comb
    begin
        lb = '0;
        lg = '0;
        lr = '0;
        eb = '0;
        eg = '0;
        er = '0;
        unique case (s2_reg.seg)
            SEG_BG:
            begin
                if (s2_reg.set)
                begin
                    lb = hi;
                    lg = lo;
                end
                if (echo)
                begin
                    er = hi;
                    eb = lo;
                end
            end
            SEG_GR:
            begin
                if (s2_reg.set)
                begin
                    lg = hi;
                    lr = lo;
                end
                if (echo)
                begin
                    eb = hi;
                    eg = lo;
                end
            end
            default:
            begin
                if (s2_reg.set)
                begin
                    lr = hi;
                    lb = lo;
                end
                if (echo)
                begin
                    eg = hi;
                    er = lo;
                end
            end
        endcase
    end

    assign sb = (COLOR_W+1)'(lb) + (COLOR_W+1)'(eb);
    assign sg = (COLOR_W+1)'(lg) + (COLOR_W+1)'(eg);
    assign sr = (COLOR_W+1)'(lr) + (COLOR_W+1)'(er);

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s2_reg       <= q_head;
            fwd_data_reg <= new_word;
        end
        if (adv && s2_valid_reg)
        begin
            out_blue_reg  <= sb[COLOR_W] ? '1 : sb[COLOR_W-1:0];
            out_green_reg <= sg[COLOR_W] ? '1 : sg[COLOR_W-1:0];
            out_red_reg   <= sr[COLOR_W] ? '1 : sr[COLOR_W-1:0];
            out_fend_reg  <= s2_reg.fend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                fwd_reg <= we && (s2_reg.addr == q_head.addr);
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_blue      = out_blue_reg;
    assign out_green     = out_green_reg;
    assign out_red       = out_red_reg;
    assign out_frame_end = out_fend_reg;

endmodule

// ===== rtl/core/threshold_color_cycle_echo_unit.sv =====
// Top level of the threshold color-cycle echo block: config registers,
// front end, item queue and back end. Uses tcce_pkg, tcce_front, tcce_queue, tcce_back.
//
// Usage:
//   Pixel beats (pix_blue/green/red, frame_end) enter on in_valid/in_stall in
//   raster order; frame_end marks the last pixel of a frame. Each beat gives
//   exactly one result beat (out_blue/green/red, out_frame_end) on
//   out_valid/out_stall, in order.
//   Throughput is one pixel per clock while out_stall is low; the history
//   memory does one read and one write per cycle, with a bypass for
//   repeated access to one pixel. An accepted beat passes the item queue,
//   the history read stage and the output register before out_valid rises.
//   APB registers: threshold_level at 0x0, warmup_frames at 0x4. Write only
//   while no beat is in flight.
//   Reset: frame counter loads one; pixel address and history bookkeeping clear;
//   history memory is not cleared; user must read it only where written, not enforced.
//   Receiver stall: the output register holds, the back end freezes, the
//   four-entry queue absorbs incoming beats, then in_stall rises.
module threshold_color_cycle_echo_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [tcce_pkg::COLOR_W-1:0] pix_blue,
    input  logic [tcce_pkg::COLOR_W-1:0] pix_green,
    input  logic [tcce_pkg::COLOR_W-1:0] pix_red,
    input  logic                         frame_end,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [tcce_pkg::COLOR_W-1:0] out_blue,
    output logic [tcce_pkg::COLOR_W-1:0] out_green,
    output logic [tcce_pkg::COLOR_W-1:0] out_red,
    output logic                         out_frame_end
);
    import tcce_pkg::*;

    logic [THRESH_W-1:0] threshold_level_reg;
    logic [WARMUP_W-1:0] warmup_frames_reg;
    tcce_reg_t           reg_sel;
    logic                cfg_write;

    logic                q_push;
    tcce_item_t          q_item;
    logic                q_full;
    logic                q_pop;
    tcce_item_t          q_head;
    logic                q_empty;

    assign pready    = 1'b1;
    assign reg_sel   = tcce_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_sel)
            REG_THRESHOLD: prdata = 32'(threshold_level_reg);
            REG_WARMUP:    prdata = 32'(warmup_frames_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_level_reg <= THRESH_RESET;
            warmup_frames_reg   <= WARMUP_RESET;
        end
        else if (cfg_write)
        begin
            if (reg_sel == REG_THRESHOLD)
            begin
                threshold_level_reg <= pwdata[THRESH_W-1:0];
            end
            else
            begin
                warmup_frames_reg <= pwdata[WARMUP_W-1:0];
            end
        end
    end

    tcce_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .threshold_level (threshold_level_reg),
        .warmup_frames   (warmup_frames_reg),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pix_blue        (pix_blue),
        .pix_green       (pix_green),
        .pix_red         (pix_red),
        .frame_end       (frame_end),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_item          (q_item)
    );

    tcce_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    tcce_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_blue      (out_blue),
        .out_green     (out_green),
        .out_red       (out_red),
        .out_frame_end (out_frame_end)
    );

endmodule

// ===== test/threshold_color_cycle_echo_unit_test.sv =====
// Self-checking bench for threshold_color_cycle_echo_unit: random pixel frames, APB register
// changes and receiver hold-offs, checked by a scoreboard.
// Depends on tcce_pkg and threshold_color_cycle_echo_unit.

typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       fend;
} color_beat_t;

class echo_scoreboard;
    int unsigned                         threshold;
    bit [15:0]                           warmup;
    bit [15:0]                           frame_number;
    int unsigned                         pixel_addr;
    bit [tcce_pkg::HISTORY_FRAMES-1:0]   history [tcce_pkg::PIXELS];
    int unsigned                         stored;
    int unsigned                         oldest;
    color_beat_t                         expected_q [$];
    int                                  errors;

    function new();
        threshold    = tcce_pkg::THRESH_RESET;
        warmup       = tcce_pkg::WARMUP_RESET;
        frame_number = '0;
        pixel_addr   = 0;
        stored       = 0;
        oldest       = 0;
        errors       = 0;
    endfunction

    function void write_reg(tcce_pkg::tcce_reg_t idx, int unsigned value);
        if (idx == tcce_pkg::REG_THRESHOLD)
        begin
            threshold = value & 8'hFF;
        end
        else
        begin
            warmup = value[15:0];
        end
    endfunction

    function int unsigned level(int unsigned k);
        return (255 * k + 10) / 20;
    endfunction

    function int unsigned sat8(int unsigned s);
        return (s > 255) ? 255 : s;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // one accepted pixel beat -> one expected color beat
    function void note_pixel(color_beat_t px);
        bit [15:0]           count;
        int unsigned         gray;
        int unsigned         phase;
        int unsigned         k;
        int unsigned         hi;
        int unsigned         lo;
        int unsigned         lb, lg, lr, eb, eg, er;
        int unsigned         slot;
        int unsigned         new_stored;
        int unsigned         new_oldest;
        int unsigned         addr;
        bit                  is_set;
        bit                  push;
        tcce_pkg::tcce_seg_t seg;
        color_beat_t         exp_beat;

        count  = frame_number + 16'd1;
        gray   = (4899 * px.red + 9617 * px.green + 1868 * px.blue + 8192) >> 14;
        is_set = gray > threshold;
        phase  = count % 60;
        seg    = tcce_pkg::tcce_seg_t'(phase / 20);
        k      = phase % 20;
        hi     = level(20 - k);
        lo     = level(k);

        lb = 0; lg = 0; lr = 0;
        eb = 0; eg = 0; er = 0;
        if (is_set)
        begin
            case (seg)
                tcce_pkg::SEG_BG: begin lb = hi; lg = lo; end
                tcce_pkg::SEG_GR: begin lg = hi; lr = lo; end
                default:          begin lr = hi; lb = lo; end
            endcase
        end

        push       = count > warmup;
        new_stored = stored;
        new_oldest = oldest;
        addr       = pixel_addr;
        if (push)
        begin
            if (stored >= tcce_pkg::HISTORY_FRAMES)
            begin
                slot       = oldest;
                new_oldest = (oldest + 1) % tcce_pkg::HISTORY_FRAMES;
            end
            else
            begin
                slot       = (oldest + stored) % tcce_pkg::HISTORY_FRAMES;
                new_stored = stored + 1;
            end
            history[addr][slot] = !is_set;
        end

        if (new_stored > 0 && history[addr][new_oldest])
        begin
            case (seg)
                tcce_pkg::SEG_BG: begin er = hi; eb = lo; end
                tcce_pkg::SEG_GR: begin eb = hi; eg = lo; end
                default:          begin eg = hi; er = lo; end
            endcase
        end

        exp_beat.blue  = 8'(sat8(lb + eb));
        exp_beat.green = 8'(sat8(lg + eg));
        exp_beat.red   = 8'(sat8(lr + er));
        exp_beat.fend  = px.fend;
        expected_q.insert(expected_q.size(), exp_beat);

        if (px.fend)
        begin
            frame_number = count;
            pixel_addr   = 0;
            stored       = new_stored;
            oldest       = new_oldest;
        end
        else
        begin
            pixel_addr = (addr + 1 < tcce_pkg::PIXELS) ? addr + 1 : 0;
        end
    endfunction

    function void check_beat(color_beat_t got);
        color_beat_t want;
        if (expected_q.size() == 0)
        begin
            $error("result beat with no pixel pending");
            errors++;
            return;
        end
        want = expected_q[0];
        expected_q.delete(0);
        if (got.blue !== want.blue)
        begin
            $error("out_blue expected %0d got %0d", want.blue, got.blue);
            errors++;
        end
        if (got.green !== want.green)
        begin
            $error("out_green expected %0d got %0d", want.green, got.green);
            errors++;
        end
        if (got.red !== want.red)
        begin
            $error("out_red expected %0d got %0d", want.red, got.red);
            errors++;
        end
        if (got.fend !== want.fend)
        begin
            $error("out_frame_end expected %0d got %0d", want.fend, got.fend);
            errors++;
        end
    endfunction
endclass

module threshold_color_cycle_echo_unit_test;
    import tcce_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 80;
    localparam int IDLE_PCT     = 30;
    localparam int MAX_RAND_LEN = 40;
    localparam int PHASE_ITEMS  = 200;
    localparam int NUM_PHASES   = 8;
    localparam int BURST_LEN    = 120;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         psel          = 1'b0;
    logic         penable       = 1'b0;
    logic         pwrite        = 1'b0;
    logic [2:0]   paddr         = '0;
    logic [31:0]  pwdata        = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         in_valid      = 1'b0;
    logic         in_stall;
    logic [7:0]   pix_blue      = '0;
    logic [7:0]   pix_green     = '0;
    logic [7:0]   pix_red       = '0;
    logic         frame_end     = 1'b0;
    logic         out_valid;
    logic         out_stall     = 1'b0;
    logic [7:0]   out_blue;
    logic [7:0]   out_green;
    logic [7:0]   out_red;
    logic         out_frame_end;

    echo_scoreboard sb = new();

    bit           idle_on  = 1'b1;
    bit           hold_req = 1'b0;
    int           quiet_cycles = 0;

    // frame-level plan, kept so that no never-written history bit is read
    bit [15:0]    plan_frames = '0;
    int           plan_stored = 0;
    int           plan_oldest = 0;
    int           slot_reach [HISTORY_FRAMES];
    int unsigned  cur_thresh = THRESH_RESET;
    bit [15:0]    cur_warmup = WARMUP_RESET;
    color_beat_t  directed_q [$];

    threshold_color_cycle_echo_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pix_blue      (pix_blue),
        .pix_green     (pix_green),
        .pix_red       (pix_red),
        .frame_end     (frame_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_blue      (out_blue),
        .out_green     (out_green),
        .out_red       (out_red),
        .out_frame_end (out_frame_end)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles > QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: check beats, random stall, long hold-off on request
    initial
    begin
        int          hold_left;
        color_beat_t got;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.blue  = out_blue;
                got.green = out_green;
                got.red   = out_red;
                got.fend  = out_frame_end;
                sb.check_beat(got);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    task automatic send_pixel(color_beat_t px);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        pix_blue  <= px.blue;
        pix_green <= px.green;
        pix_red   <= px.red;
        frame_end <= px.fend;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note_pixel(px);
    endtask

    // sends one frame of up to want pixels, shortened where the echo would
    // reach past what the read slot has ever covered
    task automatic send_frame(int want, output int len);
        bit [15:0]   count;
        bit          push;
        bit          full;
        int          wslot;
        int          rslot;
        int          nstored;
        int          room;
        int unsigned v;
        color_beat_t px;

        count   = plan_frames + 16'd1;
        push    = count > cur_warmup;
        full    = plan_stored >= HISTORY_FRAMES;
        wslot   = -1;
        rslot   = plan_oldest;
        nstored = plan_stored;
        if (push)
        begin
            if (full)
            begin
                wslot = plan_oldest;
                rslot = (plan_oldest + 1) % HISTORY_FRAMES;
            end
            else
            begin
                wslot = (plan_oldest + plan_stored) % HISTORY_FRAMES;
                nstored++;
            end
        end
        room = (nstored == 0 || rslot == wslot) ? want : slot_reach[rslot];
        len  = (want < room) ? want : room;

        for (int i = 0; i < len; i++)
        begin
            if (directed_q.size() != 0)
            begin
                px = directed_q[0];
                directed_q.delete(0);
            end
            else
            begin
                case ($urandom_range(7))
                    0:
                    begin
                        v = cur_thresh + $urandom_range(1);
                        if (v > 255)
                        begin
                            v = 255;
                        end
                        px.blue  = 8'(v);
                        px.green = 8'(v);
                        px.red   = 8'(v);
                    end
                    1:
                    begin
                        px.blue  = {8{$urandom_range(1) == 1}};
                        px.green = {8{$urandom_range(1) == 1}};
                        px.red   = {8{$urandom_range(1) == 1}};
                    end
                    default:
                    begin
                        px.blue  = 8'($urandom);
                        px.green = 8'($urandom);
                        px.red   = 8'($urandom);
                    end
                endcase
            end
            px.fend = (i == len - 1);
            send_pixel(px);
        end

        if (push)
        begin
            if (len > slot_reach[wslot])
            begin
                slot_reach[wslot] = (len > PIXELS) ? PIXELS : len;
            end
            if (full)
            begin
                plan_oldest = (plan_oldest + 1) % HISTORY_FRAMES;
            end
        end
        plan_stored = nstored;
        plan_frames = count;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // APB write followed by a read-back of the same register
    task automatic reg_write(tcce_reg_t idx, int unsigned value);
        logic [31:0] mask;
        logic [31:0] rd;
        mask    = (idx == REG_THRESHOLD) ? 32'h0000_00FF : 32'h0000_FFFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom & ~mask) | (value & mask);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        sb.write_reg(idx, value);
        if (idx == REG_THRESHOLD)
        begin
            cur_thresh = value & 8'hFF;
        end
        else
        begin
            cur_warmup = value[15:0];
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
        begin
            @(negedge clk);
        end
        rd = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if ((rd & mask) !== (value & mask))
        begin
            $error("register %s read expected %0h got %0h", idx.name(), value & mask, rd);
            sb.errors++;
        end
    endtask

    function automatic color_beat_t rgb(int b, int g, int r);
        color_beat_t px;
        px.blue  = 8'(b);
        px.green = 8'(g);
        px.red   = 8'(r);
        px.fend  = 1'b0;
        return px;
    endfunction

    function automatic void add_directed(color_beat_t px);
        directed_q.insert(directed_q.size(), px);
    endfunction

    initial
    begin
        int          len;
        int          sent;
        int          want;
        bit          paused;
        int unsigned warm;

        foreach (slot_reach[i])
        begin
            slot_reach[i] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: extremes, gray on and just above the threshold,
        // single primaries, short frames; no frame reaches the history yet
        add_directed(rgb(0, 0, 0));
        add_directed(rgb(255, 255, 255));
        add_directed(rgb(127, 127, 127));
        add_directed(rgb(128, 128, 128));
        add_directed(rgb(255, 0, 0));
        add_directed(rgb(0, 255, 0));
        add_directed(rgb(0, 0, 255));
        add_directed(rgb(1, 254, 128));
        send_frame(8, len);
        add_directed(rgb(200, 100, 50));
        send_frame(1, len);
        add_directed(rgb(126, 126, 126));
        add_directed(rgb(129, 129, 129));
        add_directed(rgb(255, 255, 0));
        send_frame(3, len);

        // first frame into the history echoes itself, sent at full rate
        drain();
        reg_write(REG_WARMUP, 0);
        reg_write(REG_THRESHOLD, 127);
        idle_on = 1'b0;
        send_frame(BURST_LEN, len);
        idle_on = 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    reg_write(REG_THRESHOLD, 0);
                    reg_write(REG_WARMUP, 0);
                end
                1:
                begin
                    reg_write(REG_THRESHOLD, 255);
                    reg_write(REG_WARMUP, 16'hFFFF);
                end
                default:
                begin
                    reg_write(REG_THRESHOLD, $urandom_range(255));
                    warm = plan_frames + $urandom_range(12);
                    reg_write(REG_WARMUP, warm & 16'hFFFF);
                end
            endcase
            if (ph == 2)
            begin
                hold_req = 1'b1;
            end
            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_ITEMS)
            begin
                if (ph == 3 && !paused && sent >= PHASE_ITEMS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
                want = ($urandom_range(4) == 0) ? 1 : $urandom_range(MAX_RAND_LEN, 1);
                send_frame(want, len);
                sent += len;
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
